// ===== sv/imm_pkg.sv =====
// ---------------------------------------------------------------------------
// imm_pkg: shared types and codes for the integer matrix multiply core
// Holds the request command codes, the internal operation codes and the
// queue entry that travels from the front end to the execution back end.
// ---------------------------------------------------------------------------
package imm_pkg;

    localparam int ValueWidth = 32;
    localparam int IndexWidth = 4;
    localparam int SizeWidth  = 5;
    localparam int QDepth     = 4;

    // Request command codes.
    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROWS_LEFT  = 2'd0;
    localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [1:0] CFG_COLS_RIGHT = 2'd2;

    localparam logic [SizeWidth-1:0] SIZE_RESET = 5'd16;

    // Operations handed to the back end.
    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_ERROR   = 2'd3;

    typedef struct packed {
        logic [1:0]                  op;
        logic [IndexWidth-1:0]       row;
        logic [IndexWidth-1:0]       col;
        logic [ValueWidth-1:0]       value;
        logic [SizeWidth-1:0]        inner;
    } entry_t;

endpackage

// ===== sv/imm_front.sv =====
// ---------------------------------------------------------------------------
// imm_front: request intake and classification
// Holds the size registers, checks each request against the sizes in force
// and turns it into a queue entry for the back end.
// ---------------------------------------------------------------------------
module imm_front #(
    parameter int MAX_DIM = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cmd,
    input  logic [imm_pkg::IndexWidth-1:0]      s_row_index,
    input  logic [imm_pkg::IndexWidth-1:0]      s_col_index,
    input  logic signed [imm_pkg::ValueWidth-1:0] s_elem_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [imm_pkg::SizeWidth-1:0]       cfg_data,
    input  logic                                q_full,
    output logic                                q_push,
    output imm_pkg::entry_t                     q_entry
);

    logic [imm_pkg::SizeWidth-1:0] rows_reg, rows_next;
    logic [imm_pkg::SizeWidth-1:0] inner_reg, inner_next;
    logic [imm_pkg::SizeWidth-1:0] cols_reg, cols_next;
    logic [imm_pkg::SizeWidth-1:0] nr, nk, nc;
    logic                          row_in_r, row_in_k, col_in_k, col_in_c;

    function automatic logic [imm_pkg::SizeWidth-1:0] clamp_size(
        input logic [imm_pkg::SizeWidth-1:0] size
    );
        if (int'(size) > MAX_DIM) begin
            return imm_pkg::SizeWidth'(MAX_DIM);
        end
        return size;
    endfunction

    assign cfg_ready = 1'b1;

    always_comb begin
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        if (cfg_valid) begin
            case (cfg_index)
                imm_pkg::CFG_ROWS_LEFT:  rows_next  = cfg_data;
                imm_pkg::CFG_INNER_SIZE: inner_next = cfg_data;
                imm_pkg::CFG_COLS_RIGHT: cols_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= imm_pkg::SIZE_RESET;
            inner_reg <= imm_pkg::SIZE_RESET;
            cols_reg  <= imm_pkg::SIZE_RESET;
        end else begin
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
        end
    end

    assign nr = clamp_size(rows_reg);
    assign nk = clamp_size(inner_reg);
    assign nc = clamp_size(cols_reg);

    assign row_in_r = imm_pkg::SizeWidth'(s_row_index) < nr;
    assign row_in_k = imm_pkg::SizeWidth'(s_row_index) < nk;
    assign col_in_k = imm_pkg::SizeWidth'(s_col_index) < nk;
    assign col_in_c = imm_pkg::SizeWidth'(s_col_index) < nc;

    // The unused command is accepted and dropped without a result.
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && (s_cmd != imm_pkg::CMD_UNUSED);

    always_comb begin
        q_entry.row   = s_row_index;
        q_entry.col   = s_col_index;
        q_entry.value = s_elem_value;
        q_entry.inner = nk;
        case (s_cmd)
            imm_pkg::CMD_WRITE_A:
                q_entry.op = (row_in_r && col_in_k) ? imm_pkg::OP_WRITE_A : imm_pkg::OP_ERROR;
            imm_pkg::CMD_WRITE_B:
                q_entry.op = (row_in_k && col_in_c) ? imm_pkg::OP_WRITE_B : imm_pkg::OP_ERROR;
            imm_pkg::CMD_READ:
                q_entry.op = (row_in_r && col_in_c) ? imm_pkg::OP_READ : imm_pkg::OP_ERROR;
            default:
                q_entry.op = imm_pkg::OP_ERROR;
        endcase
    end

endmodule

// ===== sv/imm_queue.sv =====
// ---------------------------------------------------------------------------
// imm_queue: classified request queue
// A small first-in first-out buffer that decouples the front end from the
// execution back end.
// ---------------------------------------------------------------------------
module imm_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  imm_pkg::entry_t push_entry,
    input  logic            pop,
    output imm_pkg::entry_t pop_entry,
    output logic            empty,
    output logic            full
);

    localparam int PtrWidth = $clog2(imm_pkg::QDepth);
    localparam int CntWidth = $clog2(imm_pkg::QDepth + 1);

    imm_pkg::entry_t       slots_reg [imm_pkg::QDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CntWidth'(imm_pkg::QDepth));
    assign pop_entry = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(imm_pkg::QDepth - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(imm_pkg::QDepth - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/imm_back.sv =====
// ---------------------------------------------------------------------------
// imm_back: element stores and multiply-accumulate engine
// Carries out queued requests: element writes into the A and B stores and
// product reads through a pipelined multiply-accumulate over the inner size.
// ---------------------------------------------------------------------------
module imm_back #(
    parameter int MAX_DIM = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_empty,
    input  imm_pkg::entry_t                        q_entry,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [imm_pkg::ValueWidth-1:0]  m_product_value,
    output logic                                   m_index_error
);

    localparam int Depth     = MAX_DIM * MAX_DIM;
    localparam int AddrWidth = $clog2(Depth);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [imm_pkg::ValueWidth-1:0] left_mem  [Depth];
    logic [imm_pkg::ValueWidth-1:0] right_mem [Depth];
    logic [imm_pkg::ValueWidth-1:0] left_q, right_q;

    logic [1:0]                     state_reg, state_next;
    logic [AddrWidth-1:0]           la_reg, la_next;
    logic [AddrWidth-1:0]           rb_reg, rb_next;
    logic [imm_pkg::SizeWidth-1:0]  cnt_reg, cnt_next;
    logic [imm_pkg::SizeWidth-1:0]  nk_reg, nk_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic                           mul_vld_reg, mul_vld_next;
    logic [imm_pkg::ValueWidth-1:0] prod_reg, prod_next;
    logic [imm_pkg::ValueWidth-1:0] acc_reg, acc_next;
    logic                           m_valid_reg, m_valid_next;
    logic [imm_pkg::ValueWidth-1:0] m_value_reg, m_value_next;
    logic                           m_err_reg, m_err_next;

    logic                           out_free;
    logic                           rd_en, wa_en, wb_en;
    logic [31:0]                    elem_addr_w, row_base_w;
    logic [AddrWidth-1:0]           elem_addr;

    assign row_base_w  = 32'(q_entry.row) * 32'(MAX_DIM);
    assign elem_addr_w = row_base_w + 32'(q_entry.col);
    assign elem_addr   = elem_addr_w[AddrWidth-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == ST_MAC) && (cnt_reg != nk_reg);

    always_comb begin
        state_next   = state_reg;
        la_next      = la_reg;
        rb_next      = rb_reg;
        cnt_next     = cnt_reg;
        nk_next      = nk_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_err_next   = m_err_reg;
        q_pop        = 1'b0;
        wa_en        = 1'b0;
        wb_en        = 1'b0;
        rd_vld_next  = rd_en;
        mul_vld_next = rd_vld_reg;
        prod_next    = left_q * right_q;

        if (mul_vld_reg) begin
            acc_next = acc_reg + prod_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    case (q_entry.op)
                        imm_pkg::OP_WRITE_A: begin
                            wa_en        = 1'b1;
                            m_valid_next = 1'b1;
                            m_value_next = '0;
                            m_err_next   = 1'b0;
                        end
                        imm_pkg::OP_WRITE_B: begin
                            wb_en        = 1'b1;
                            m_valid_next = 1'b1;
                            m_value_next = '0;
                            m_err_next   = 1'b0;
                        end
                        imm_pkg::OP_READ: begin
                            // Walk row i of A by one and column j of B by MAX_DIM.
                            la_next    = row_base_w[AddrWidth-1:0];
                            rb_next    = AddrWidth'(q_entry.col);
                            cnt_next   = '0;
                            nk_next    = q_entry.inner;
                            acc_next   = '0;
                            state_next = ST_MAC;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_value_next = '0;
                            m_err_next   = 1'b1;
                        end
                    endcase
                end
            end
            ST_MAC: begin
                if (rd_en) begin
                    la_next  = la_reg + 1'b1;
                    rb_next  = rb_reg + AddrWidth'(MAX_DIM);
                    cnt_next = cnt_reg + 1'b1;
                end else if (!rd_vld_reg && !mul_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = acc_reg;
                    m_err_next   = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wa_en) begin
            left_mem[elem_addr] <= q_entry.value;
        end
        if (rd_en) begin
            left_q <= left_mem[la_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (wb_en) begin
            right_mem[elem_addr] <= q_entry.value;
        end
        if (rd_en) begin
            right_q <= right_mem[rb_reg];
        end
    end

    always_ff @(posedge aclk) begin
        la_reg      <= la_next;
        rb_reg      <= rb_next;
        nk_reg      <= nk_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        m_value_reg <= m_value_next;
        m_err_reg   <= m_err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= mul_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_product_value = m_value_reg;
    assign m_index_error   = m_err_reg;

endmodule

// ===== sv/integer_matrix_multiply_core.sv =====
// ---------------------------------------------------------------------------
// integer_matrix_multiply_core: element-wise integer matrix multiply
// Stores signed 32-bit elements of A and B and returns product elements.
// ---------------------------------------------------------------------------
// Each request on the s_ channel writes one element of A or B or reads one
// element of the product A*B, and every request except the unused command
// code returns exactly one result on the m_ channel, in request order. A
// write or a rejected request completes straight from the engine's idle
// state; a read runs one multiply-accumulate step per cycle through the
// one read port of each element store and its two-stage read and multiply
// pipeline. A four-entry request queue lets the intake keep accepting
// while the engine works or a result waits. Sizes above MAX_DIM act as
// MAX_DIM. Store contents are undefined until written; no clearing pass
// is made after reset.
module integer_matrix_multiply_core #(
    parameter int MAX_DIM = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_cmd,
    input  logic [imm_pkg::IndexWidth-1:0]         s_row_index,
    input  logic [imm_pkg::IndexWidth-1:0]         s_col_index,
    input  logic signed [imm_pkg::ValueWidth-1:0]  s_elem_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [imm_pkg::ValueWidth-1:0]  m_product_value,
    output logic                                   m_index_error,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [imm_pkg::SizeWidth-1:0]          cfg_data
);

    imm_pkg::entry_t push_entry;
    imm_pkg::entry_t pop_entry;
    logic            q_push, q_pop, q_empty, q_full;

    imm_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_row_index (s_row_index),
        .s_col_index (s_col_index),
        .s_elem_value(s_elem_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    imm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_entry(push_entry),
        .pop       (q_pop),
        .pop_entry (pop_entry),
        .empty     (q_empty),
        .full      (q_full)
    );

    imm_back #(
        .MAX_DIM(MAX_DIM)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_entry        (pop_entry),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_product_value(m_product_value),
        .m_index_error  (m_index_error)
    );

endmodule

// ===== verif/integer_matrix_multiply_core_tb.sv =====
// ---------------------------------------------------------------------------
// integer_matrix_multiply_core_tb: self-checking bench for the matrix core
// Writes elements of A and B, reads product elements and checks every result
// against a local predictor. Directed cases cover value and size extremes,
// rejected indexes and the unused command. Random traffic then runs under
// several size settings with random stalls on both sides and one long
// receiver hold-off.
// ---------------------------------------------------------------------------
module integer_matrix_multiply_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Dim        = 16;
    localparam int SettleTime = 48;
    localparam int StallLimit = 4000;
    localparam int ShownLimit = 10;

    typedef struct packed {
        logic [imm_pkg::ValueWidth-1:0] product;
        logic                           flagged;
    } product_t;

    logic                                  aclk = 1'b0;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    logic [1:0]                            s_cmd;
    logic [imm_pkg::IndexWidth-1:0]        s_row_index;
    logic [imm_pkg::IndexWidth-1:0]        s_col_index;
    logic signed [imm_pkg::ValueWidth-1:0] s_elem_value;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [imm_pkg::ValueWidth-1:0] m_product_value;
    logic                                  m_index_error;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [1:0]                            cfg_index;
    logic [imm_pkg::SizeWidth-1:0]         cfg_data;

    // Predictor state: both element stores, which entries hold data, and sizes.
    logic [imm_pkg::ValueWidth-1:0] left_matrix [Dim][Dim];
    logic [imm_pkg::ValueWidth-1:0] right_matrix [Dim][Dim];
    bit                             left_written [Dim][Dim];
    bit                             right_written [Dim][Dim];
    logic [imm_pkg::SizeWidth-1:0]  size_rows;
    logic [imm_pkg::SizeWidth-1:0]  size_inner;
    logic [imm_pkg::SizeWidth-1:0]  size_cols;

    product_t expected_products [$];

    int  sent_count;
    int  good_reads;
    int  flagged_count;
    int  unused_count;
    int  size_settings;
    int  results_seen;
    int  mismatch_count;
    int  hold_request;
    bit  quiet_flow;

    integer_matrix_multiply_core #(
        .MAX_DIM(Dim)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .s_elem_value   (s_elem_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_product_value(m_product_value),
        .m_index_error  (m_index_error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int active_size(input logic [imm_pkg::SizeWidth-1:0] setting);
        return (setting > Dim) ? Dim : int'(setting);
    endfunction

    // Updates the stores and returns 1 when the request produces a result.
    function automatic bit apply_matrix_request(input logic [1:0] cmd,
                                                input logic [imm_pkg::IndexWidth-1:0] row,
                                                input logic [imm_pkg::IndexWidth-1:0] col,
                                                input logic [imm_pkg::ValueWidth-1:0] value,
                                                output product_t outcome);
        int nr;
        int nk;
        int nc;
        logic [imm_pkg::ValueWidth-1:0] acc;
        nr = active_size(size_rows);
        nk = active_size(size_inner);
        nc = active_size(size_cols);
        outcome.product = '0;
        outcome.flagged = 1'b0;
        case (cmd)
            imm_pkg::CMD_WRITE_A: begin
                if (row < nr && col < nk) begin
                    left_matrix[row][col] = value;
                    left_written[row][col] = 1'b1;
                end else begin
                    outcome.flagged = 1'b1;
                end
            end
            imm_pkg::CMD_WRITE_B: begin
                if (row < nk && col < nc) begin
                    right_matrix[row][col] = value;
                    right_written[row][col] = 1'b1;
                end else begin
                    outcome.flagged = 1'b1;
                end
            end
            imm_pkg::CMD_READ: begin
                if (row < nr && col < nc) begin
                    acc = '0;
                    for (int k = 0; k < nk; k++) begin
                        acc = acc + left_matrix[row][k] * right_matrix[k][col];
                    end
                    outcome.product = acc;
                end else begin
                    outcome.flagged = 1'b1;
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet_flow) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [imm_pkg::ValueWidth-1:0] pick_element();
        case ($urandom_range(0, 19))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    // Entered and left at a falling edge; valid stays high when the next
    // request follows without a gap.
    task automatic send_request(input logic [1:0] cmd, input int row, input int col,
                                input logic [imm_pkg::ValueWidth-1:0] value);
        int gap;
        product_t outcome;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_row_index  <= imm_pkg::IndexWidth'(row);
        s_col_index  <= imm_pkg::IndexWidth'(col);
        s_elem_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (apply_matrix_request(cmd, imm_pkg::IndexWidth'(row), imm_pkg::IndexWidth'(col),
                                 value, outcome)) begin
            expected_products.push_back(outcome);
            sent_count++;
            if (outcome.flagged) begin
                flagged_count++;
            end else if (cmd == imm_pkg::CMD_READ) begin
                good_reads++;
            end
        end else begin
            unused_count++;
        end
        @(negedge aclk);
    endtask

    // Reads product element (r, c), first writing any operand never written.
    task automatic request_product(input int r, input int c);
        int nk;
        nk = active_size(size_inner);
        if (r < active_size(size_rows) && c < active_size(size_cols)) begin
            for (int k = 0; k < nk; k++) begin
                if (!left_written[r][k]) begin
                    send_request(imm_pkg::CMD_WRITE_A, r, k, pick_element());
                end
                if (!right_written[k][c]) begin
                    send_request(imm_pkg::CMD_WRITE_B, k, c, pick_element());
                end
            end
        end
        send_request(imm_pkg::CMD_READ, r, c, $urandom());
    endtask

    task automatic cfg_write(input logic [1:0] index,
                             input logic [imm_pkg::SizeWidth-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (index)
            imm_pkg::CFG_ROWS_LEFT:  size_rows  = data;
            imm_pkg::CFG_INNER_SIZE: size_inner = data;
            imm_pkg::CFG_COLS_RIGHT: size_cols  = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_sizes(input int rows, input int inner, input int cols);
        cfg_write(imm_pkg::CFG_ROWS_LEFT, imm_pkg::SizeWidth'(rows));
        cfg_write(imm_pkg::CFG_INNER_SIZE, imm_pkg::SizeWidth'(inner));
        cfg_write(imm_pkg::CFG_COLS_RIGHT, imm_pkg::SizeWidth'(cols));
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    // An unused command leaves no expectation behind, so the settle time
    // covers whatever the core may still be chewing on.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (expected_products.size() != 0) @(posedge aclk);
        repeat (SettleTime) @(negedge aclk);
    endtask

    task automatic random_traffic(input int items);
        int first;
        int roll;
        int nr;
        int nk;
        int nc;
        int r;
        int c;
        int k;
        first = sent_count;
        while (sent_count - first < items) begin
            nr = active_size(size_rows);
            nk = active_size(size_inner);
            nc = active_size(size_cols);
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                r = $urandom_range(0, nr - 1);
                c = $urandom_range(0, nc - 1);
                if ($urandom_range(0, 2) == 0) begin
                    k = $urandom_range(0, nk - 1);
                    if ($urandom_range(0, 1) == 0) begin
                        send_request(imm_pkg::CMD_WRITE_A, r, k, pick_element());
                    end else begin
                        send_request(imm_pkg::CMD_WRITE_B, k, c, pick_element());
                    end
                end
                request_product(r, c);
            end else if (roll < 82) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_request(imm_pkg::CMD_WRITE_A, $urandom_range(0, nr - 1),
                                 $urandom_range(0, nk - 1), pick_element());
                end else begin
                    send_request(imm_pkg::CMD_WRITE_B, $urandom_range(0, nk - 1),
                                 $urandom_range(0, nc - 1), pick_element());
                end
            end else if (roll < 95) begin
                r = $urandom_range(0, Dim - 1);
                c = $urandom_range(0, Dim - 1);
                case ($urandom_range(0, 2))
                    0: send_request(imm_pkg::CMD_WRITE_A, r, c, pick_element());
                    1: send_request(imm_pkg::CMD_WRITE_B, r, c, pick_element());
                    default: request_product(r, c);
                endcase
            end else begin
                send_request(imm_pkg::CMD_UNUSED, $urandom_range(0, Dim - 1),
                             $urandom_range(0, Dim - 1), $urandom());
            end
        end
    endtask

    task automatic run_phase(input int rows, input int inner, input int cols,
                             input int items, input bit no_gaps);
        drain_pipeline();
        set_sizes(rows, inner, cols);
        quiet_flow = no_gaps;
        random_traffic(items);
        quiet_flow = 1'b0;
    endtask

    task automatic test_directed_basics();
        set_sizes(2, 2, 2);
        // Largest and smallest values; the read wraps past 32 bits.
        send_request(imm_pkg::CMD_WRITE_A, 0, 0, 32'h7fff_ffff);
        send_request(imm_pkg::CMD_WRITE_A, 0, 1, 32'h8000_0000);
        send_request(imm_pkg::CMD_WRITE_B, 0, 0, 32'h7fff_ffff);
        send_request(imm_pkg::CMD_WRITE_B, 1, 0, 32'hffff_ffff);
        send_request(imm_pkg::CMD_READ, 0, 0, 32'hffff_ffff);
        send_request(imm_pkg::CMD_WRITE_A, 1, 0, 32'h0000_0000);
        send_request(imm_pkg::CMD_WRITE_A, 1, 1, 32'hffff_ffff);
        send_request(imm_pkg::CMD_WRITE_B, 0, 1, 32'h8000_0000);
        send_request(imm_pkg::CMD_WRITE_B, 1, 1, 32'h8000_0000);
        send_request(imm_pkg::CMD_READ, 1, 1, 32'h0000_0000);
        send_request(imm_pkg::CMD_READ, 0, 1, 32'h5a5a_a5a5);
        // Indexes past the configured sizes are flagged and store nothing; the unused command returns no result.
        send_request(imm_pkg::CMD_WRITE_A, 2, 0, 32'h1234_5678);
        send_request(imm_pkg::CMD_WRITE_B, 0, 2, 32'h1234_5678);
        send_request(imm_pkg::CMD_READ, 2, 1, 32'h0000_0000);
        send_request(imm_pkg::CMD_READ, 15, 15, 32'h0000_0000);
        send_request(imm_pkg::CMD_UNUSED, 15, 15, 32'hffff_ffff);
        send_request(imm_pkg::CMD_UNUSED, 0, 0, 32'h0000_0000);
    endtask

    task automatic test_size_edges();
        drain_pipeline();
        // An inner size of zero gives the empty sum and rejects every write.
        set_sizes(2, 0, 2);
        send_request(imm_pkg::CMD_READ, 0, 0, $urandom());
        send_request(imm_pkg::CMD_WRITE_A, 0, 0, $urandom());
        drain_pipeline();
        set_sizes(0, 2, 2);
        send_request(imm_pkg::CMD_READ, 0, 0, $urandom());
        drain_pipeline();
        // Shrinking and restoring the sizes must not disturb stored elements.
        set_sizes(2, 2, 2);
        send_request(imm_pkg::CMD_READ, 0, 0, $urandom());
        drain_pipeline();
        // Settings above the maximum dimension act as the maximum.
        set_sizes(31, 1, 20);
        send_request(imm_pkg::CMD_WRITE_A, 15, 0, pick_element());
        send_request(imm_pkg::CMD_WRITE_B, 0, 15, pick_element());
        send_request(imm_pkg::CMD_READ, 15, 15, $urandom());
        send_request(imm_pkg::CMD_WRITE_A, 15, 1, pick_element());
        drain_pipeline();
        set_sizes(31, 17, 20);
        send_request(imm_pkg::CMD_WRITE_B, 15, 15, pick_element());
    endtask

    task automatic test_backpressure();
        drain_pipeline();
        set_sizes(4, 3, 5);
        quiet_flow = 1'b1;
        hold_request = 300;
        repeat (24) request_product($urandom_range(0, 3), $urandom_range(0, 4));
        quiet_flow = 1'b0;
    endtask

    task automatic test_random_sizes();
        run_phase(4, 3, 5, 90, 1'b0);
        run_phase(1, 1, 1, 60, 1'b1);
        run_phase(16, 16, 16, 100, 1'b0);
        run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                  90, 1'b0);
        run_phase($urandom_range(1, 16), $urandom_range(1, 8), $urandom_range(1, 16),
                  90, 1'b0);
        run_phase(16, 1, 16, 70, 1'b0);
        run_phase(1, 16, 1, 60, 1'b0);
    endtask

    task automatic report_mismatch(input string what, input product_t want);
        mismatch_count++;
        if (mismatch_count <= ShownLimit) begin
            $display("Mismatch at %0t: %s, expected product %h flag %b, got product %h flag %b",
                     $realtime, what, want.product, want.flagged, m_product_value,
                     m_index_error);
        end
    endtask

    always @(posedge aclk) begin : check_results
        product_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (expected_products.size() == 0) begin
                want = 'x;
                report_mismatch("result with no request waiting", want);
            end else begin
                want = expected_products.pop_front();
                if (m_product_value !== want.product || m_index_error !== want.flagged) begin
                    report_mismatch("wrong result", want);
                end
            end
        end
    end

    // The receiver stalls at random, or holds off for a requested stretch.
    initial begin : result_sink
        int stall;
        int held;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                held = hold_request;
                hold_request = 0;
                m_ready <= 1'b0;
                repeat (held) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < StallLimit) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 &&
                m_ready === 1'b1) || (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                 StallLimit, expected_products.size());
        $display("[integer_matrix_multiply_core] ERROR");
        $finish;
    end

    initial begin : main_sequence
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_cmd        = imm_pkg::CMD_WRITE_A;
        s_row_index  = '0;
        s_col_index  = '0;
        s_elem_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = imm_pkg::CFG_ROWS_LEFT;
        cfg_data     = '0;
        quiet_flow   = 1'b0;
        hold_request = 0;
        size_rows    = imm_pkg::SIZE_RESET;
        size_inner   = imm_pkg::SIZE_RESET;
        size_cols    = imm_pkg::SIZE_RESET;
        for (int r = 0; r < Dim; r++) begin
            for (int c = 0; c < Dim; c++) begin
                left_written[r][c]  = 1'b0;
                right_written[r][c] = 1'b0;
            end
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_basics();
        test_size_edges();
        test_backpressure();
        test_random_sizes();
        drain_pipeline();

        $display("Sent %0d requests: %0d product reads, %0d flagged indexes, %0d unused codes",
                 sent_count, good_reads, flagged_count, unused_count);
        $display("Ran %0d size settings; checked %0d results, %0d mismatches",
                 size_settings, results_seen, mismatch_count);
        if (mismatch_count == 0 && expected_products.size() == 0) begin
            $display("[integer_matrix_multiply_core] OK");
        end else begin
            $display("[integer_matrix_multiply_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== integer_matrix_multiply_core.f =====
sv/imm_pkg.sv
sv/imm_front.sv
sv/imm_queue.sv
sv/imm_back.sv
sv/integer_matrix_multiply_core.sv
verif/integer_matrix_multiply_core_tb.sv
